>>> rtl/core/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
// No dependencies; imported by every module of the block.
`default_nettype none

package qrs_pkg;

  localparam int COEF_WIDTH_DEF     = 16;
  localparam int ROOT_FRAC_BITS_DEF = 16;
  localparam int ROOT_WIDTH         = 32;

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2,
    CNT_ANY  = 2'd3
  } count_t;

  typedef enum logic [2:0] {
    SOL_NONE = 3'd0,
    SOL_ANY  = 3'd1,
    SOL_LIN  = 3'd2,
    SOL_DBL  = 3'd3,
    SOL_TWO  = 3'd4
  } sol_t;

  localparam int SOL_W = $bits(sol_t);

endpackage

`default_nettype wire

>>> rtl/core/qrs_disc.sv
// Discriminant stages: products in the first register, b*b - 4ac and case sort in the second.
// Depends on qrs_pkg.
`default_nettype none

module qrs_disc #(
  parameter int W = qrs_pkg::COEF_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] a_in,
  input  logic signed [W-1:0] b_in,
  input  logic signed [W-1:0] c_in,
  output logic                out_valid,
  output logic signed [W-1:0] a_out,
  output logic signed [W-1:0] b_out,
  output logic signed [W-1:0] c_out,
  output logic [2*W:0]        disc,
  output qrs_pkg::sol_t       sol
);
  import qrs_pkg::*;

  localparam int PW  = 2 * W;
  localparam int DSW = 2 * W + 3;

  logic                 v1;
  logic signed [W-1:0]  a1, b1, c1;
  logic signed [PW-1:0] bb1, ac1;
  logic signed [PW-1:0] bb_next, ac_next;

  logic signed [DSW-1:0] d_full;
  logic                  dzero;
  sol_t                  sol_next;

  assign bb_next = b_in * b_in;
  assign ac_next = a_in * c_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= a_in;
      b1    <= b_in;
      c1    <= c_in;
      bb1   <= bb_next;
      ac1   <= ac_next;
      a_out <= a1;
      b_out <= b1;
      c_out <= c1;
      disc  <= d_full[2*W:0];
      sol   <= sol_next;
    end
  end

  assign d_full = $signed({{3{bb1[PW-1]}}, bb1}) - $signed({ac1[PW-1], ac1, 2'b00});
  assign dzero  = (d_full == '0);

  always_comb begin
    if (a1 == '0) begin
      if (b1 == '0) begin
        sol_next = (c1 == '0) ? SOL_ANY : SOL_NONE;
      end else begin
        sol_next = SOL_LIN;
      end
    end else if (d_full[DSW-1]) begin
      sol_next = SOL_NONE;
    end else if (dzero) begin
      sol_next = SOL_DBL;
    end else begin
      sol_next = SOL_TWO;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/qrs_sqrt.sv
// Pipelined restoring integer square root, one result bit per register stage.
// Depends on qrs_pkg only for the house import; sideband rides along in tag.
`default_nettype none

module qrs_sqrt #(
  parameter int RW    = qrs_pkg::COEF_WIDTH_DEF + 1,
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   rad,
  input  logic [TAG_W-1:0]  tag_in,
  output logic              out_valid,
  output logic [RW-1:0]     root,
  output logic [TAG_W-1:0]  tag_out
);
  import qrs_pkg::*;

  localparam int RAD_W = 2 * RW;
  localparam int REM_W = RW + 1;
  localparam int SH_W  = RW + 2;

  logic [RW-1:0]    vld;
  logic [RAD_W-1:0] rad_r  [RW];
  logic [REM_W-1:0] rem_r  [RW];
  logic [RW-1:0]    root_r [RW];
  logic [TAG_W-1:0] tag_r  [RW];

  logic [RAD_W-1:0] rad_next  [RW];
  logic [REM_W-1:0] rem_next  [RW];
  logic [RW-1:0]    root_next [RW];
  logic [TAG_W-1:0] tag_next  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_step
    logic [RAD_W-1:0] rad_i;
    logic [REM_W-1:0] rem_i;
    logic [RW-1:0]    root_i;
    logic [TAG_W-1:0] tag_i;
    logic [SH_W-1:0]  rem_sh, trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign tag_i  = tag_in;
    end else begin : g_next
      assign rad_i  = rad_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign root_i = root_r[i-1];
      assign tag_i  = tag_r[i-1];
    end

    assign rem_sh = {rem_i[RW-1:0], rad_i[RAD_W-1 -: 2]};
    assign trial  = {root_i, 2'b01};
    assign ge     = (rem_sh >= trial);

    assign rad_next[i]  = rad_i << 2;
    assign rem_next[i]  = ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
    assign root_next[i] = {root_i[RW-2:0], ge};
    assign tag_next[i]  = tag_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < RW; i++) begin
        rad_r[i]  <= rad_next[i];
        rem_r[i]  <= rem_next[i];
        root_r[i] <= root_next[i];
        tag_r[i]  <= tag_next[i];
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = root_r[RW-1];
  assign tag_out   = tag_r[RW-1];

endmodule

`default_nettype wire

>>> rtl/core/qrs_div.sv
// Pipelined restoring unsigned divider, one quotient bit per register stage.
// Depends on qrs_pkg only for the house import; sideband rides along in tag.
`default_nettype none

module qrs_div #(
  parameter int NW    = 34,
  parameter int DW    = 17,
  parameter int TAG_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NW-1:0]     num,
  input  logic [DW-1:0]     den,
  input  logic [TAG_W-1:0]  tag_in,
  output logic              out_valid,
  output logic [NW-1:0]     quo,
  output logic [TAG_W-1:0]  tag_out
);
  import qrs_pkg::*;

  localparam int SH_W = DW + 1;

  logic [NW-1:0]    vld;
  logic [NW-1:0]    nq_r  [NW];
  logic [DW-1:0]    rem_r [NW];
  logic [DW-1:0]    den_r [NW];
  logic [TAG_W-1:0] tag_r [NW];

  logic [NW-1:0]    nq_next  [NW];
  logic [DW-1:0]    rem_next [NW];
  logic [DW-1:0]    den_next [NW];
  logic [TAG_W-1:0] tag_next [NW];

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic [NW-1:0]    nq_i;
    logic [DW-1:0]    rem_i;
    logic [DW-1:0]    den_i;
    logic [TAG_W-1:0] tag_i;
    logic [SH_W-1:0]  rem_sh, den_x;
    logic             ge;

    if (i == 0) begin : g_first
      assign nq_i  = num;
      assign rem_i = '0;
      assign den_i = den;
      assign tag_i = tag_in;
    end else begin : g_next
      assign nq_i  = nq_r[i-1];
      assign rem_i = rem_r[i-1];
      assign den_i = den_r[i-1];
      assign tag_i = tag_r[i-1];
    end

    assign rem_sh = {rem_i, nq_i[NW-1]};
    assign den_x  = {1'b0, den_i};
    assign ge     = (rem_sh >= den_x);

    assign nq_next[i]  = {nq_i[NW-2:0], ge};
    assign rem_next[i] = ge ? DW'(rem_sh - den_x) : rem_sh[DW-1:0];
    assign den_next[i] = den_i;
    assign tag_next[i] = tag_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NW; i++) begin
        nq_r[i]  <= nq_next[i];
        rem_r[i] <= rem_next[i];
        den_r[i] <= den_next[i];
        tag_r[i] <= tag_next[i];
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quo       = nq_r[NW-1];
  assign tag_out   = tag_r[NW-1];

endmodule

`default_nettype wire

>>> rtl/core/quadratic_root_solver.sv
// Quadratic root solver: a*x^2 + b*x + c = 0 with signed fixed-point coefficients.
// Top level; depends on qrs_pkg, qrs_disc, qrs_sqrt and qrs_div.
//
// Usage:
//   Input channel: coef_a, coef_b, coef_c with in_valid / in_ready. One request
//   is taken at each edge where both are high; a new request may follow every
//   cycle unless the output stalls. Output channel: root_count, root_minus,
//   root_plus, saturated with out_valid / out_ready; exactly one result per
//   request, in order. The pipeline runs two discriminant stages, COEF_WIDTH+1
//   square root stages, one numerator stage, COEF_WIDTH+2+ROOT_FRAC_BITS
//   divider stages and the output register. Throughput is one request per
//   cycle while in_ready is high.
//   Roots are signed with ROOT_FRAC_BITS fraction bits, truncated toward zero,
//   clamped to 32 bits with saturated set on a clamp; absent roots read zero.
//   Reset (rst, synchronous) empties the pipeline; no request is in flight after it.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready drops in the same cycle; nothing is lost or repeated.
`default_nettype none

module quadratic_root_solver #(
  parameter int COEF_WIDTH     = qrs_pkg::COEF_WIDTH_DEF,
  parameter int ROOT_FRAC_BITS = qrs_pkg::ROOT_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COEF_WIDTH-1:0]        coef_a,
  input  logic signed [COEF_WIDTH-1:0]        coef_b,
  input  logic signed [COEF_WIDTH-1:0]        coef_c,
  output logic                                out_valid,
  input  logic                                out_ready,
  output qrs_pkg::count_t                     root_count,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_minus,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_plus,
  output logic                                saturated
);
  import qrs_pkg::*;

  localparam int W     = COEF_WIDTH;
  localparam int F     = ROOT_FRAC_BITS;
  localparam int RW    = W + 1;
  localparam int NMW   = W + 2;
  localparam int NW    = NMW + F;
  localparam int DNW   = W + 1;
  localparam int XW    = W + 3;
  localparam int STW   = SOL_W + 3 * W;
  localparam int MTW   = SOL_W + 1;
  localparam int QX    = (NW > ROOT_WIDTH + 1) ? NW : ROOT_WIDTH + 1;
  localparam logic [QX-1:0] LIM_POS = QX'({1'b0, {(ROOT_WIDTH-1){1'b1}}});
  localparam logic [QX-1:0] LIM_NEG = QX'({1'b1, {(ROOT_WIDTH-1){1'b0}}});

  logic en;

  logic                v2;
  logic signed [W-1:0] a2, b2, c2;
  logic [2*W:0]        d2;
  sol_t                sol2;

  logic                v3;
  logic [RW-1:0]       s3;
  logic [STW-1:0]      tag3;
  sol_t                sol3;
  logic signed [W-1:0] a3, b3, c3;

  logic signed [XW-1:0] ax, bx, cx, sx, nm_x, np_x, dn_x;
  logic signed [XW-1:0] nm_abs, np_abs, dn_abs;

  logic           v4;
  logic [NMW-1:0] nm_mag, np_mag;
  logic [DNW-1:0] dn_mag;
  logic           neg_m, neg_p;
  sol_t           sol4;

  logic           v5, v5p;
  logic [NW-1:0]  quo_m, quo_p;
  logic [MTW-1:0] mtag5;
  logic           ptag5;
  sol_t           sol5;

  logic [ROOT_WIDTH-1:0] rm_val, rp_val;
  logic                  rm_sat, rp_sat;
  count_t                count_next;
  logic [ROOT_WIDTH-1:0] minus_next, plus_next;
  logic                  sat_next;

  function automatic logic [ROOT_WIDTH:0] clamp_root(input logic [QX-1:0] q, input logic neg);
    logic [ROOT_WIDTH-1:0] r;
    logic                  s;
    r = '0;
    s = 1'b0;
    if (neg) begin
      if (q > LIM_NEG) begin
        s = 1'b1;
        r = LIM_NEG[ROOT_WIDTH-1:0];
      end else begin
        r = ROOT_WIDTH'(0) - q[ROOT_WIDTH-1:0];
      end
    end else begin
      if (q > LIM_POS) begin
        s = 1'b1;
        r = LIM_POS[ROOT_WIDTH-1:0];
      end else begin
        r = q[ROOT_WIDTH-1:0];
      end
    end
    return {s, r};
  endfunction

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  qrs_disc #(
    .W (W)
  ) u_disc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .a_in      (coef_a),
    .b_in      (coef_b),
    .c_in      (coef_c),
    .out_valid (v2),
    .a_out     (a2),
    .b_out     (b2),
    .c_out     (c2),
    .disc      (d2),
    .sol       (sol2)
  );

  qrs_sqrt #(
    .RW    (RW),
    .TAG_W (STW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .rad       ({1'b0, d2}),
    .tag_in    ({sol2, a2, b2, c2}),
    .out_valid (v3),
    .root      (s3),
    .tag_out   (tag3)
  );

  assign sol3 = sol_t'(tag3[STW-1 -: SOL_W]);
  assign a3   = tag3[3*W-1 -: W];
  assign b3   = tag3[2*W-1 -: W];
  assign c3   = tag3[W-1:0];

  assign ax = XW'(a3);
  assign bx = XW'(b3);
  assign cx = XW'(c3);
  assign sx = $signed({2'b00, s3});

  always_comb begin
    np_x = -bx + sx;
    if (sol3 == SOL_LIN) begin
      nm_x = -cx;
      dn_x = bx;
    end else begin
      nm_x = -bx - sx;
      dn_x = ax <<< 1;
    end
    nm_abs = nm_x[XW-1] ? -nm_x : nm_x;
    np_abs = np_x[XW-1] ? -np_x : np_x;
    dn_abs = dn_x[XW-1] ? -dn_x : dn_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_mag <= nm_abs[NMW-1:0];
      np_mag <= np_abs[NMW-1:0];
      dn_mag <= dn_abs[DNW-1:0];
      neg_m  <= nm_x[XW-1] ^ dn_x[XW-1];
      neg_p  <= np_x[XW-1] ^ dn_x[XW-1];
      sol4   <= sol3;
    end
  end

  qrs_div #(
    .NW    (NW),
    .DW    (DNW),
    .TAG_W (MTW)
  ) u_div_minus (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .num       ({nm_mag, {F{1'b0}}}),
    .den       (dn_mag),
    .tag_in    ({sol4, neg_m}),
    .out_valid (v5),
    .quo       (quo_m),
    .tag_out   (mtag5)
  );

  qrs_div #(
    .NW    (NW),
    .DW    (DNW),
    .TAG_W (1)
  ) u_div_plus (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .num       ({np_mag, {F{1'b0}}}),
    .den       (dn_mag),
    .tag_in    (neg_p),
    .out_valid (v5p),
    .quo       (quo_p),
    .tag_out   (ptag5)
  );

  assign sol5                 = sol_t'(mtag5[MTW-1 -: SOL_W]);
  assign {rm_sat, rm_val}     = clamp_root(QX'(quo_m), mtag5[0]);
  assign {rp_sat, rp_val}     = clamp_root(QX'(quo_p), ptag5);

  always_comb begin
    count_next = CNT_NONE;
    minus_next = '0;
    plus_next  = '0;
    sat_next   = 1'b0;
    unique case (sol5)
      SOL_NONE: count_next = CNT_NONE;
      SOL_ANY:  count_next = CNT_ANY;
      SOL_LIN: begin
        count_next = CNT_ONE;
        minus_next = rm_val;
        sat_next   = rm_sat;
      end
      SOL_DBL: begin
        count_next = CNT_ONE;
        minus_next = rm_val;
        plus_next  = rp_val;
        sat_next   = rm_sat | rp_sat;
      end
      SOL_TWO: begin
        count_next = CNT_TWO;
        minus_next = rm_val;
        plus_next  = rp_val;
        sat_next   = rm_sat | rp_sat;
      end
      default: count_next = CNT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_count <= count_next;
      root_minus <= minus_next;
      root_plus  <= plus_next;
      saturated  <= sat_next;
    end
  end

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (root_count == CNT_NONE || root_count == CNT_ANY) |->
      root_minus == '0 && root_plus == '0 && !saturated)
    else $error("absent roots not zero");

  a_sat_needs_root: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> root_count == CNT_ONE || root_count == CNT_TWO)
    else $error("saturation without a root");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    v5 == v5p)
    else $error("divider lanes out of step");

endmodule

`default_nettype wire

>>> dv/qrs_checker.sv
// Checker for the quadratic root solver: watches both channels, predicts each result.
// Depends on qrs_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 100ps

module qrs_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [15:0]        coef_a,
  input  logic signed [15:0]        coef_b,
  input  logic signed [15:0]        coef_c,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  qrs_pkg::count_t           root_count,
  input  logic signed [31:0]        root_minus,
  input  logic signed [31:0]        root_plus,
  input  logic                      saturated,
  output int                        errors,
  output int                        pending
);
  import qrs_pkg::*;

  typedef struct packed {
    count_t             cnt;
    logic signed [31:0] rm;
    logic signed [31:0] rp;
    logic               sat;
  } roots_t;

  roots_t expected_roots[$];

  assign pending = expected_roots.size();

  function automatic logic signed [31:0] scaled_quot(input longint num, input longint den,
                                                      inout logic sat);
    longint q;
    q = (num * 65536) / den;
    if (q > 64'sd2147483647) begin
      sat = 1'b1;
      q = 64'sd2147483647;
    end else if (q < -64'sd2147483648) begin
      sat = 1'b1;
      q = -64'sd2147483648;
    end
    return q[31:0];
  endfunction

  function automatic longint floor_sqrt(input longint d);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'sd1 << 31;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      if (mid * mid <= d) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic roots_t solve_roots(input longint a, input longint b, input longint c);
    roots_t r;
    longint d, s;
    r = '{cnt: CNT_NONE, rm: '0, rp: '0, sat: 1'b0};
    if (a == 0) begin
      if (b == 0) r.cnt = (c == 0) ? CNT_ANY : CNT_NONE;
      else begin
        r.rm = scaled_quot(-c, b, r.sat);
        r.cnt = CNT_ONE;
      end
    end else begin
      d = b * b - 4 * a * c;
      if (d == 0) begin
        r.rm = scaled_quot(-b, 2 * a, r.sat);
        r.rp = r.rm;
        r.cnt = CNT_ONE;
      end else if (d > 0) begin
        s = floor_sqrt(d);
        r.rm = scaled_quot(-b - s, 2 * a, r.sat);
        r.rp = scaled_quot(-b + s, 2 * a, r.sat);
        r.cnt = CNT_TWO;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    roots_t e;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_roots.push_back(solve_roots(coef_a, coef_b, coef_c));
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          e = expected_roots.pop_front();
          if (root_count !== e.cnt) report_mismatch("root_count", root_count, e.cnt);
          if (root_minus !== e.rm) report_mismatch("root_minus", root_minus, e.rm);
          if (root_plus !== e.rp) report_mismatch("root_plus", root_plus, e.rp);
          if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
        end
      end
    end
  end
endmodule

>>> dv/tb_top.sv
// Top of the quadratic root solver testbench: clock, reset, requests and verdict.
// Depends on qrs_pkg, quadratic_root_solver and qrs_checker.
`timescale 1ns / 100ps

module tb_top;
  import qrs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] coef_a = '0, coef_b = '0, coef_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  count_t root_count;
  logic signed [31:0] root_minus, root_plus;
  logic saturated;
  int errors, pending;
  int send_idle_pct = 9, recv_idle_pct = 50;
  bit hold_off = 1'b0;
  longint cycles = 0;

  always #5 clk = ~clk;

  quadratic_root_solver dut (.*);

  qrs_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(negedge clk)
    out_ready <= !rst && !hold_off && ($urandom_range(99) >= recv_idle_pct);

  task automatic send_request(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(5))
      0: return '0;
      1: return 16'h0100 << $urandom_range(6);
      2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      3: return 16'($urandom_range(15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int n);
    logic [15:0] a, b, r1, r2;
    repeat (n) begin
      if ($urandom_range(3) == 0) begin
        r1 = 16'($urandom_range(64)) - 16'd32;
        r2 = 16'($urandom_range(64)) - 16'd32;
        a = 16'($urandom_range(7)) + 16'd1;
        b = -(a * (r1 + r2));
        send_request(a, b, a * r1 * r2);
      end else send_request(rand_coef(), rand_coef(), rand_coef());
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    send_request('0, '0, '0);
    send_request('0, '0, 16'h0100);
    send_request('0, 16'h0100, 16'h0200);
    send_request('0, 16'h0001, 16'h8000);
    send_request('0, 16'hffff, 16'h7fff);
    send_request('0, 16'h8000, 16'h7fff);
    send_request(16'h0100, 16'hfe00, 16'h0100);
    send_request(16'h0100, '0, 16'h0100);
    send_request(16'h0100, '0, 16'hff00);
    send_request(16'h0100, 16'hfd00, 16'h0200);
    send_request(16'h7fff, 16'h7fff, 16'h8000);
    send_request(16'h8000, 16'h8000, 16'h7fff);
    send_request(16'h8000, 16'h8000, 16'h8000);
    send_request(16'h0001, 16'h7fff, 16'h8000);
    send_request(16'hffff, 16'h8000, 16'h7fff);
    send_request(16'h7fff, '0, '0);
    send_request(16'h0001, 16'h0002, 16'h0001);
    send_request(16'hffff, 16'h5555, 16'haaaa);
    random_phase(180);
    send_idle_pct = 50;
    recv_idle_pct = 9;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(200);
    join
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(200);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
